// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants for the bounded array list
// Holds the list geometry, the command and status codes and the control
// bundle that is broadcast from the decoder to every storage cell.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int IDX_W  = 6;
	localparam int CAP_W  = 7;
	localparam int POS_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int GRP    = 8;
	localparam int NGRP   = DEPTH / GRP;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_GET    = 3'd3,
		CMD_REMOVE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Per-request control seen by every cell; op flags are already qualified
	typedef struct packed {
		logic             do_add;
		logic             do_set;
		logic             do_ins;
		logic             do_rem;
		logic [POS_W-1:0] index;
		logic [CNT_W-1:0] fill;
	} ctrl_t;

endpackage

// ===== rtl/bal_cell.sv =====
// ----------------------------------------------------------------------------
// bal_cell: one storage cell of the list
// Holds one word and picks its next value from itself, the request data or
// its left or right neighbor. Also offers its word for an indexed read.
// ----------------------------------------------------------------------------
module bal_cell (
	input  logic                      clk,
	input  logic [bal_pkg::POS_W-1:0]  pos,
	input  bal_pkg::ctrl_t            ctrl,
	input  logic [bal_pkg::WORD_W-1:0] wdata,
	input  logic [bal_pkg::WORD_W-1:0] left,
	input  logic [bal_pkg::WORD_W-1:0] right,
	input  logic [bal_pkg::POS_W-1:0]  rd_index,
	output logic [bal_pkg::WORD_W-1:0] word,
	output logic [bal_pkg::WORD_W-1:0] rd_word
);
	import bal_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_d;
	logic [CNT_W-1:0]  pos_c;
	logic              at_index;

	assign pos_c    = CNT_W'(pos);
	assign at_index = (pos == ctrl.index);

	always_comb begin
		word_d = word_q;
		if (ctrl.do_add && pos_c == ctrl.fill) begin
			word_d = wdata;
		end else if (ctrl.do_set && at_index) begin
			word_d = wdata;
		end else if (ctrl.do_ins) begin
			// open a gap at the index, move the tail up
			if (at_index) begin
				word_d = wdata;
			end else if (pos > ctrl.index && pos_c <= ctrl.fill) begin
				word_d = left;
			end
		end else if (ctrl.do_rem) begin
			// close the gap, move the tail down
			if (pos >= ctrl.index && (pos_c + CNT_W'(1)) < ctrl.fill) begin
				word_d = right;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word    = word_q;
	assign rd_word = (pos == rd_index) ? word_q : '0;

endmodule

// ===== rtl/bal_ctrl.sv =====
// ----------------------------------------------------------------------------
// bal_ctrl: request decoder
// Checks a registered request against fill and capacity, produces the
// status, the next fill and the control broadcast to the cells.
// ----------------------------------------------------------------------------
module bal_ctrl (
	input  logic                     exec,
	input  logic [2:0]               cmd,
	input  logic [bal_pkg::IDX_W-1:0] index,
	input  logic [bal_pkg::CNT_W-1:0] fill,
	input  logic [bal_pkg::CAP_W-1:0] cap,
	output bal_pkg::ctrl_t           ctrl,
	output bal_pkg::status_t         status,
	output logic [bal_pkg::CNT_W-1:0] fill_next,
	output logic                     rd_ok
);
	import bal_pkg::*;

	logic [CNT_W-1:0] cap_lim;
	logic [CNT_W-1:0] index_c;
	logic             full;
	logic             out_rng;

	assign cap_lim = (cap > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap);
	assign index_c = CNT_W'(index);
	assign full    = (fill >= cap_lim);
	assign out_rng = (index_c >= fill);

	always_comb begin
		ctrl        = '0;
		ctrl.index  = POS_W'(index);
		ctrl.fill   = fill;
		status      = ST_OK;
		fill_next   = fill;
		rd_ok       = 1'b0;
		unique case (cmd)
			CMD_ADD: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.do_add = exec;
					fill_next   = fill + CNT_W'(1);
				end
			end
			CMD_SET: begin
				if (out_rng) begin
					status = ST_RANGE;
				end else begin
					ctrl.do_set = exec;
					rd_ok       = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (out_rng) begin
					status = ST_RANGE;
				end else begin
					ctrl.do_ins = exec;
					fill_next   = fill + CNT_W'(1);
				end
			end
			CMD_GET: begin
				if (out_rng) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (fill == '0) begin
					status = ST_EMPTY;
				end else if (out_rng) begin
					status = ST_RANGE;
				end else begin
					ctrl.do_rem = exec;
					rd_ok       = 1'b1;
					fill_next   = fill - CNT_W'(1);
				end
			end
			default: begin
				// unused codes: report ok, change nothing
			end
		endcase
	end

endmodule

// ===== rtl/bounded_array_list.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list: ordered list of signed 32-bit words with shift cells
// A request (start high while busy is low) is registered, executed in the
// next cycle, and answered by a one-cycle done strobe in the cycle after.
// ----------------------------------------------------------------------------
// A request is first registered, and the addressed word is read into the
// first level of the read tree; then, in the execute cycle, the request is
// decoded against fill and capacity and every cell is updated at once. busy
// is high during the execute cycle only, so no new request is taken while
// one executes; one request's done strobe may overlap the acceptance of the
// next. done, status, value and count are valid for exactly one cycle and
// cannot be held off, so the receiver must take them when done is high.
// Insert and remove shift the whole tail in the execute cycle: the store is
// a row of DEPTH cells, each loading from the request, its left neighbor or
// its right neighbor. Words are kept at reset; fill count, flags and
// capacity do not. capacity may be rewritten between requests with cap_we;
// lowering it below the fill drops nothing, it only refuses add and insert.
// ----------------------------------------------------------------------------
module bounded_array_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [bal_pkg::IDX_W-1:0]  index,
	input  logic signed [bal_pkg::WORD_W-1:0] data,
	input  logic                       cap_we,
	input  logic [bal_pkg::CAP_W-1:0]  cap_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic signed [bal_pkg::WORD_W-1:0] value,
	output logic [bal_pkg::CNT_W-1:0]  count
);
	import bal_pkg::*;

	// request stage
	logic              exec_s1;
	logic [2:0]        cmd_s1;
	logic [IDX_W-1:0]  index_s1;
	logic [WORD_W-1:0] data_s1;
	logic [WORD_W-1:0] grp_s1 [NGRP];

	// list state
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  fill_q;

	// result registers
	logic              done_q;
	status_t           status_q;
	logic [WORD_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;

	// cell row
	logic [WORD_W-1:0] cell_word [DEPTH];
	logic [WORD_W-1:0] cell_rd   [DEPTH];
	logic [WORD_W-1:0] grp_d     [NGRP];
	logic [WORD_W-1:0] rd_word;

	ctrl_t             ctrl;
	status_t           st;
	logic [CNT_W-1:0]  fill_next;
	logic              rd_ok;
	logic              accept;

	assign accept = start && !busy;
	assign busy   = exec_s1;

	// Capacity register, written whenever cap_we is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_we) begin
			cap_q <= cap_data;
		end
	end

	// Register the request; the cells still hold the old words here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_s1 <= 1'b0;
		end else begin
			exec_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			index_s1 <= index;
			data_s1  <= data;
			grp_s1   <= grp_d;
		end
	end

	// Row of cells; the ends see zero past the last neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[g+1];
		end
		bal_cell u_cell (
			.clk      (clk),
			.pos      (POS_W'(g)),
			.ctrl     (ctrl),
			.wdata    (data_s1),
			.left     (left_w),
			.right    (right_w),
			.rd_index (POS_W'(index)),
			.word     (cell_word[g]),
			.rd_word  (cell_rd[g])
		);
	end

	// Read tree, first level: combine each group of cells at accept time
	always_comb begin
		for (int k = 0; k < NGRP; k++) begin
			grp_d[k] = '0;
			for (int j = 0; j < GRP; j++) begin
				grp_d[k] = grp_d[k] | cell_rd[k*GRP + j];
			end
		end
	end

	// Read tree, second level: combine the registered groups
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < NGRP; k++) begin
			rd_word = rd_word | grp_s1[k];
		end
	end

	bal_ctrl u_ctrl (
		.exec      (exec_s1),
		.cmd       (cmd_s1),
		.index     (index_s1),
		.fill      (fill_q),
		.cap       (cap_q),
		.ctrl      (ctrl),
		.status    (st),
		.fill_next (fill_next),
		.rd_ok     (rd_ok)
	);

	// Advance the fill count and capture the result in the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= exec_s1;
			if (exec_s1) begin
				fill_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_s1) begin
			status_q <= st;
			value_q  <= rd_ok ? rd_word : '0;
			count_q  <= fill_next;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign value  = value_q;
	assign count  = count_q;

endmodule

// ===== rtl/bal_checker.sv =====
// ----------------------------------------------------------------------------
// bal_checker: port-level checks for the bounded array list
// Watches the request and result ports and flags timing or value slips.
// ----------------------------------------------------------------------------
module bal_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [1:0]                 status,
	input logic [bal_pkg::WORD_W-1:0] value,
	input logic [bal_pkg::CNT_W-1:0]  count
);
	import bal_pkg::*;

	// an accepted request goes to execute next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not enter execute");

	// execute is always answered by one strobe in the next cycle
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle not followed by a result");

	// no result without a preceding execute cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request");

	// a refused request reports no value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> value == '0)
		else $error("nonzero value on a failed request");

	// count never exceeds the store
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= CNT_W'(DEPTH))
		else $error("count beyond store depth");

endmodule

bind bounded_array_list bal_checker u_bal_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.value  (value),
	.count  (count)
);
